### rtl/lrast_pkg.sv
// ----------------------------------------------------------------------------
// lrast_pkg: shared constants for the range add / range sum block
// Leaf count, index widths, operation codes, word width and a lowest set bit helper.
// ----------------------------------------------------------------------------
package lrast_pkg;

   localparam int LEAVES = 1024;
   localparam int IDX_W  = $clog2(LEAVES);
   localparam int POS_W  = IDX_W + 1;
   localparam int WORD_W = 32;

   localparam logic [1:0] OP_POINT_ADD = 2'd0;
   localparam logic [1:0] OP_RANGE_ADD = 2'd1;
   localparam logic [1:0] OP_RANGE_SUM = 2'd2;
   localparam logic [1:0] OP_NONE      = 2'd3;

   localparam logic [POS_W-1:0] LEAF_COUNT = POS_W'(LEAVES);

   // lowest set bit of a tree position
   function automatic logic [POS_W-1:0] low_bit(input logic [POS_W-1:0] pos);
      low_bit = pos & (~pos + POS_W'(1));
   endfunction

endpackage

### rtl/lazy_range_add_sum_tree_top.sv
// ----------------------------------------------------------------------------
// lazy_range_add_sum_tree_top: range add and range sum over 1024 leaves
// Two interleaved binary indexed trees in one ram, walked by a sequencer
// with one shared adder pair and one shared 32x11 multiplier.
// ----------------------------------------------------------------------------
//
//  channel   ports                                    transfer
//  request   start, busy, req_*                       start high, busy low
//  response  rsp_valid, rsp_range_sum                 one cycle strobe
//
//  an add makes two tree walks of up to log2(LEAVES)+1 nodes, each node read
//  and then written back through the ram's read and write ports.
//  a sum makes two prefix walks of up to log2(LEAVES) nodes, each followed
//  by a multiply step and a subtract step.
//  an empty range or the unused code finishes at once, busy stays low.
//  after reset a clearing pass writes zero to every ram word with busy high.
//  the receiver cannot stall: a sum appears for exactly one cycle.
//
module lazy_range_add_sum_tree_top
   import lrast_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_operation,
   input  logic [IDX_W-1:0]         req_first_index,
   input  logic [IDX_W-1:0]         req_last_index,
   input  logic signed [WORD_W-1:0] req_add_value,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_range_sum
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_U_MUL, ST_U_RD, ST_U_WR,
      ST_Q_RD, ST_Q_ACC, ST_Q_MUL, ST_Q_SUB
   } state_type;

   state_type          state_ff;
   logic [POS_W-1:0]   idx_ff;
   logic [POS_W-1:0]   lo_ff;
   logic [POS_W-1:0]   hi_ff;
   logic               pass_ff;
   logic [WORD_W-1:0]  val_ff;
   logic [WORD_W-1:0]  prod_ff;
   logic [WORD_W-1:0]  acc1_ff;
   logic [WORD_W-1:0]  acc2_ff;
   logic [WORD_W-1:0]  part_ff;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_sum_ff;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [2*WORD_W-1:0]  wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [2*WORD_W-1:0]  rd_data;
   logic [WORD_W-1:0]    mul_a;
   logic [POS_W-1:0]     mul_b;
   logic [WORD_W+POS_W-1:0] mul_p;
   logic [WORD_W-1:0]    d1;
   logic [WORD_W-1:0]    d2;
   logic [WORD_W-1:0]    prefix;

   lrast_ram #(.ADDR_W(IDX_W), .DATA_W(2*WORD_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared multiplier operands
   always_comb begin
      mul_a = (state_ff == ST_Q_MUL) ? acc1_ff : val_ff;
      if (state_ff == ST_Q_MUL) begin
         mul_b = pass_ff ? lo_ff : hi_ff;
      end else begin
         mul_b = pass_ff ? hi_ff : lo_ff;
      end
      mul_p = {{POS_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
   end

   // update deltas: start of range adds, one past its end subtracts
   assign d1 = pass_ff ? (~val_ff + WORD_W'(1)) : val_ff;
   assign d2 = pass_ff ? (~prod_ff + WORD_W'(1)) : prod_ff;
   assign prefix = prod_ff - acc2_ff;

   // ram port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDX_W-1:0] - IDX_W'(1);
      wr_data = {rd_data[2*WORD_W-1:WORD_W] + d1, rd_data[WORD_W-1:0] + d2};
      rd_en   = 1'b0;
      rd_addr = idx_ff[IDX_W-1:0] - IDX_W'(1);
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = '0;
         end
         ST_U_RD: rd_en = (idx_ff <= LEAF_COUNT) && (idx_ff != '0);
         ST_U_WR: wr_en = 1'b1;
         ST_Q_RD: rd_en = (idx_ff != '0);
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               idx_ff <= idx_ff + POS_W'(1);
               if (idx_ff == LEAF_COUNT - POS_W'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  lo_ff   <= {1'b0, req_first_index};
                  hi_ff   <= (req_operation == OP_POINT_ADD)
                             ? {1'b0, req_first_index} + POS_W'(1)
                             : {1'b0, req_last_index} + POS_W'(1);
                  val_ff  <= req_add_value;
                  pass_ff <= 1'b0;
                  acc1_ff <= '0;
                  acc2_ff <= '0;
                  idx_ff  <= {1'b0, req_last_index} + POS_W'(1);
                  priority if (req_operation == OP_NONE) begin
                     state_ff <= ST_IDLE;
                  end else if (req_operation == OP_RANGE_SUM) begin
                     if (req_first_index > req_last_index) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_sum_ff   <= '0;
                     end else begin
                        state_ff <= ST_Q_RD;
                     end
                  end else if (req_operation == OP_RANGE_ADD &&
                               req_first_index > req_last_index) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_U_MUL;
                  end
               end
            end
            // product for the second tree, then walk up from the position
            ST_U_MUL: begin
               prod_ff  <= mul_p[WORD_W-1:0];
               idx_ff   <= pass_ff ? hi_ff + POS_W'(1) : lo_ff + POS_W'(1);
               state_ff <= ST_U_RD;
            end
            // a step past the root wraps the position to zero
            ST_U_RD: begin
               if (idx_ff > LEAF_COUNT || idx_ff == '0) begin
                  pass_ff  <= 1'b1;
                  state_ff <= pass_ff ? ST_IDLE : ST_U_MUL;
               end else begin
                  state_ff <= ST_U_WR;
               end
            end
            ST_U_WR: begin
               idx_ff   <= idx_ff + low_bit(idx_ff);
               state_ff <= ST_U_RD;
            end
            // prefix walk down toward zero
            ST_Q_RD: begin
               state_ff <= (idx_ff == '0) ? ST_Q_MUL : ST_Q_ACC;
            end
            ST_Q_ACC: begin
               acc1_ff  <= acc1_ff + rd_data[2*WORD_W-1:WORD_W];
               acc2_ff  <= acc2_ff + rd_data[WORD_W-1:0];
               idx_ff   <= idx_ff - low_bit(idx_ff);
               state_ff <= ST_Q_RD;
            end
            ST_Q_MUL: begin
               prod_ff  <= mul_p[WORD_W-1:0];
               state_ff <= ST_Q_SUB;
            end
            ST_Q_SUB: begin
               if (pass_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_sum_ff   <= part_ff - prefix;
                  state_ff     <= ST_IDLE;
               end else begin
                  part_ff  <= prefix;
                  pass_ff  <= 1'b1;
                  acc1_ff  <= '0;
                  acc2_ff  <= '0;
                  idx_ff   <= lo_ff;
                  state_ff <= ST_Q_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

endmodule

### rtl/lrast_ram.sv
// ----------------------------------------------------------------------------
// lrast_ram: simple dual port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrast_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // storage and read register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lrast_checker.sv
// ----------------------------------------------------------------------------
// lrast_checker: port level checks for the range add / range sum block
// Watches the command and response ports and is bound to the top level.
// ----------------------------------------------------------------------------
module lrast_checker
   import lrast_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [1:0]               req_operation,
   input logic [IDX_W-1:0]         req_first_index,
   input logic [IDX_W-1:0]         req_last_index,
   input logic                     rsp_valid,
   input logic signed [WORD_W-1:0] rsp_range_sum
);

   // clearing pass keeps the block busy after reset
   a_clear_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // adds never give a response
   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == OP_POINT_ADD ||
                         req_operation == OP_RANGE_ADD) |=> !rsp_valid)
      else $error("response after add");

   // unused code gives nothing
   a_none_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_operation == OP_NONE |=> !rsp_valid && !busy)
      else $error("unused code acted");

   // reversed sum answers zero at once
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_operation == OP_RANGE_SUM &&
      req_first_index > req_last_index |=> rsp_valid && rsp_range_sum == '0)
      else $error("empty range sum wrong");

endmodule

bind lazy_range_add_sum_tree_top lrast_checker u_lrast_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .req_first_index (req_first_index),
   .req_last_index  (req_last_index),
   .rsp_valid       (rsp_valid),
   .rsp_range_sum   (rsp_range_sum)
);

### bench/tb_lazy_range_add_sum_tree_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lazy_range_add_sum_tree_top: self-checking bench for range add / sum
// Drives point adds, range adds, range sums and the unused opcode through the
// start/busy command port. A flat array of leaf values predicts every sum,
// and each sum strobe is checked against the oldest predicted sum.
// ----------------------------------------------------------------------------
module tb_lazy_range_add_sum_tree_top;
   import lrast_pkg::*;

   typedef struct packed {
      logic [1:0]        op;
      logic [IDX_W-1:0]  first;
      logic [IDX_W-1:0]  last;
      logic [WORD_W-1:0] value;
   } command_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_operation;
   logic [IDX_W-1:0]         req_first_index;
   logic [IDX_W-1:0]         req_last_index;
   logic signed [WORD_W-1:0] req_add_value;
   logic                     rsp_valid;
   logic signed [WORD_W-1:0] rsp_range_sum;

   command_type       pending_cmds[$];
   logic [WORD_W-1:0] expected_sums[$];
   logic [WORD_W-1:0] leaf_value[LEAVES];
   int                failures;
   int                gap_left;

   lazy_range_add_sum_tree_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_first_index(req_first_index),
      .req_last_index(req_last_index), .req_add_value(req_add_value),
      .rsp_valid(rsp_valid), .rsp_range_sum(rsp_range_sum)
   );

   // clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // apply one accepted command to the leaf array, return whether a sum results
   function automatic bit apply_command(input command_type c,
                                        output logic [WORD_W-1:0] total);
      total = '0;
      case (c.op)
         OP_POINT_ADD: begin
            if (c.first < LEAVES) leaf_value[c.first] += c.value;
            return 1'b0;
         end
         OP_RANGE_ADD: begin
            for (int i = c.first; i <= c.last && i < LEAVES; i++)
               leaf_value[i] += c.value;
            return 1'b0;
         end
         OP_RANGE_SUM: begin
            for (int i = c.first; i <= c.last && i < LEAVES; i++)
               total += leaf_value[i];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // driver: one transfer when start is high and busy is low
   always @(posedge clock) begin
      command_type       c;
      logic [WORD_W-1:0] total;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            c = '{req_operation, req_first_index, req_last_index, req_add_value};
            if (apply_command(c, total)) expected_sums.push_back(total);
         end
         if (start && busy) begin
            // hold the current command
         end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            start           <= 1'b1;
            req_operation   <= c.op;
            req_first_index <= c.first;
            req_last_index  <= c.last;
            req_add_value   <= c.value;
            // no idling over the last part of the run
            if (pending_cmds.size() > 200 && $urandom_range(0, 7) == 0)
               gap_left <= $urandom_range(1, 15);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each sum strobe with the oldest expected sum
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected sum, expected none, actual %h", $time, rsp_range_sum);
            failures++;
         end else begin
            if (rsp_range_sum !== expected_sums[0]) begin
               $display("%0t: range_sum mismatch, expected %h, actual %h",
                        $time, expected_sums[0], rsp_range_sum);
               failures++;
            end
            void'(expected_sums.pop_front());
         end
      end
   end

   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return IDX_W'($urandom_range(0, 15));
         3:       return IDX_W'(LEAVES - 1 - $urandom_range(0, 15));
         default: return IDX_W'($urandom());
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 4))
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2:       return 32'hffffffff;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_cmd(input logic [1:0] op, input int f, input int l,
                            input logic [WORD_W-1:0] v);
      pending_cmds.push_back('{op, IDX_W'(f), IDX_W'(l), v});
   endtask

   // stimulus
   initial begin
      logic [IDX_W-1:0] a, b, t;
      int               r;
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_NONE;
      req_first_index = '0;
      req_last_index  = '0;
      req_add_value   = '0;
      failures        = 0;
      gap_left        = 0;
      foreach (leaf_value[i]) leaf_value[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every opcode, reversed ranges, single leaves
      queue_cmd(OP_RANGE_SUM, 0, LEAVES - 1, 0);
      queue_cmd(OP_POINT_ADD, 0, 0, 32'h7fffffff);
      queue_cmd(OP_POINT_ADD, LEAVES - 1, 0, 32'h80000000);
      queue_cmd(OP_RANGE_ADD, 0, LEAVES - 1, 32'hffffffff);
      queue_cmd(OP_RANGE_SUM, 0, LEAVES - 1, 0);
      queue_cmd(OP_RANGE_SUM, 0, 0, 32'hffffffff);
      queue_cmd(OP_RANGE_SUM, LEAVES - 1, LEAVES - 1, 0);
      queue_cmd(OP_RANGE_ADD, 700, 300, 32'h12345678);
      queue_cmd(OP_RANGE_SUM, 700, 300, 0);
      queue_cmd(OP_RANGE_SUM, 300, 700, 0);
      queue_cmd(OP_NONE, 0, LEAVES - 1, 32'h55555555);
      queue_cmd(OP_RANGE_SUM, 0, LEAVES - 1, 0);
      queue_cmd(OP_RANGE_ADD, 5, 5, 32'haaaaaaaa);
      queue_cmd(OP_POINT_ADD, 5, 1, 32'h00000001);
      queue_cmd(OP_RANGE_ADD, 511, 512, 32'h40000000);
      queue_cmd(OP_RANGE_SUM, 4, 6, 0);
      queue_cmd(OP_RANGE_SUM, 510, 513, 0);
      queue_cmd(OP_RANGE_SUM, 1, LEAVES - 2, 0);

      // random: mostly adds and sums over varied ranges
      for (int n = 0; n < 1200; n++) begin
         a = pick_index();
         b = pick_index();
         if ($urandom_range(0, 9) != 0 && a > b) begin
            t = a; a = b; b = t;
         end
         if ($urandom_range(0, 3) == 0) b = a + IDX_W'($urandom_range(0, 8));
         r = $urandom_range(0, 19);
         queue_cmd(r < 4 ? OP_POINT_ADD : r < 10 ? OP_RANGE_ADD :
                   r < 19 ? OP_RANGE_SUM : OP_NONE, a, b, pick_value());
      end

      wait (pending_cmds.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      wait (expected_sums.size() == 0);
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
rtl/lrast_pkg.sv
rtl/lrast_ram.sv
rtl/lazy_range_add_sum_tree_top.sv
rtl/lrast_checker.sv
bench/tb_lazy_range_add_sum_tree_top.sv
